// File: sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CRM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CRM_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/crm_pkg.sv
package crm_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_WINDOW_DEF  = 4096;

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int SCALE_W    = 24;
    localparam int FS_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CUR_W      = 16;
    localparam int SCALE_FRAC = 16;
    localparam int Q4_SHIFT   = 4;

    // Window actions
    typedef enum logic [MODE_W-1:0] {
        MODE_CAL = 2'd0,
        MODE_DC  = 2'd1,
        MODE_AC  = 2'd2
    } t_mode;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST      = 24'd1729600;
    localparam logic [FS_W-1:0]    FULL_SCALE_RST = 11'd1024;

    // Saturation limits of the current result
    localparam logic [CUR_W:0] CUR_POS_MAX = 17'd32767;
    localparam logic [CUR_W:0] CUR_NEG_MAX = 17'd32768;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic take;
        logic clear;
        logic ac;
    } t_acc_ctl;

endpackage

// File: sv/crm_in_if.sv
interface crm_in_if
    import crm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: sv/crm_out_if.sv
interface crm_out_if
    import crm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [CUR_W-1:0]     current_ma;
    logic [SAMPLE_BITS+3:0]      offset_out;
    logic [MODE_W-1:0]           done_mode;
    logic                        window_overflow;

    modport source (
        output valid, output current_ma, output offset_out,
        output done_mode, output window_overflow, input ready
    );
    modport sink (
        input valid, input current_ma, input offset_out,
        input done_mode, input window_overflow, output ready
    );
endinterface

// File: sv/crm_alu.sv
module crm_alu #(
    parameter int WIDTH = 8
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_res,
    output logic             o_ge
);
    logic [WIDTH:0] w_full;

    // Add or subtract; carry out of a subtract means a >= b
    assign w_full = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (WIDTH+1)'(i_sub);
    assign o_res  = w_full[WIDTH-1:0];
    assign o_ge   = w_full[WIDTH];
endmodule

// File: sv/crm_accum.sv
module crm_accum
    import crm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_acc_ctl                                      i_ctl,
    input  logic [SAMPLE_BITS-1:0]                        i_sample,
    input  logic [SAMPLE_BITS+Q4_SHIFT-1:0]               i_offset,
    output logic [2*SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]   o_sum,
    output logic [$clog2(MAX_WINDOW+1)-1:0]               o_count,
    output logic                                          o_ovf
);
    localparam int OFS_W = SAMPLE_BITS + Q4_SHIFT;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_WINDOW);

    logic [SUM_W-1:0]         r_sum;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic [OFS_W-1:0]         w_s16;
    logic [OFS_W-1:0]         w_diff;
    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] w_sq;
    logic [SUM_W-1:0]         w_add;

    // Offset-removed magnitude, truncated to whole counts, and its square
    assign w_s16  = {i_sample, {Q4_SHIFT{1'b0}}};
    assign w_diff = (w_s16 >= i_offset) ? (w_s16 - i_offset) : (i_offset - w_s16);
    assign w_mag  = w_diff[OFS_W-1:Q4_SHIFT];
    assign w_sq   = w_mag * w_mag;
    assign w_add  = i_ctl.ac ? SUM_W'(w_sq) : SUM_W'(i_sample);

    // Accumulate one sample, drop it once the window is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_ctl.take) begin
            if (r_count >= CNT_W'(MAX_WINDOW)) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + w_add;
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_ovf   = r_ovf;
endmodule

// File: sv/current_sensor_rms_meter.sv
// Current meter for Hall-sensor ADC samples. Samples arrive on i_in, one
// beat each, with last marking the final sample of a measurement window;
// each window gives one beat on o_out. Mode 2 reports the RMS of the
// offset-removed samples, mode 1 the mean minus the offset, both scaled by
// the Q8.16 mA-per-count register, rounded and saturated to 16 bits signed;
// mode 0 stores the window mean as the new Q10.4 offset and reports zero.
// Writing full_scale reloads the offset to half of full scale. Samples past
// MAX_WINDOW are dropped and flagged in window_overflow. Each sample goes
// through an accept step and an accumulate step before the next is taken.
// The end-of-window work runs on one shared add/subtract unit: a restoring
// divider at one quotient bit per cycle (NUM_W = 2*SAMPLE_BITS +
// log2(MAX_WINDOW) + 29 steps), a shift-add multiplier at one multiplier
// bit per cycle and a bit-pair square root. During the end-of-window work
// i_in is not ready; o_out holds a finished result so the next window can
// start while it waits.
`include "assert_macros.svh"

module current_sensor_rms_meter
    import crm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    crm_in_if.sink                i_in,
    crm_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SB     = SAMPLE_BITS;
    localparam int OFS_W  = SB + Q4_SHIFT;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = 2 * SB + $clog2(MAX_WINDOW);
    localparam int MAG_W  = SUM_W + Q4_SHIFT;
    localparam int NUM_W  = MAG_W + SCALE_W + 1;
    localparam int DEN_W  = CNT_W + SCALE_FRAC + Q4_SHIFT;
    localparam int MLT_W  = (SCALE_W > CNT_W) ? SCALE_W : CNT_W;
    localparam int SQ_W   = SB + 3;
    localparam int IT_W   = $clog2(NUM_W + 1);
    localparam int FSQ_W  = FS_W + Q4_SHIFT - 1;
    localparam int CMP_W  = (FSQ_W > OFS_W) ? FSQ_W : OFS_W;

    localparam logic [OFS_W-1:0] OFS_MAX = '1;
    localparam int OFS_MAX_I = (1 << OFS_W) - 1;
    localparam int FS_HALF_Q4 = int'(FULL_SCALE_RST) * (2 ** (Q4_SHIFT - 1));
    localparam int OFS_RST = (FS_HALF_Q4 > OFS_MAX_I) ? OFS_MAX_I : FS_HALF_Q4;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ACC   = 11'b000_0000_0010,
        S_SETUP = 11'b000_0000_0100,
        S_OMUL  = 11'b000_0000_1000,
        S_DIFF  = 11'b000_0001_0000,
        S_NEG   = 11'b000_0010_0000,
        S_SMUL  = 11'b000_0100_0000,
        S_RND   = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_SQRT  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [SB-1:0]       r_smp;
    logic                r_last;
    t_mode               r_mode;
    logic [SCALE_W-1:0]  r_scale;
    logic [OFS_W-1:0]    r_offset;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [DEN_W:0]      r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [MLT_W-1:0]    r_mlt, n_mlt;
    logic [IT_W-1:0]     r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic [SQ_W-1:0]     r_sqr, n_sqr;
    logic [SB-1:0]       r_root, n_root;

    logic                    r_out_valid;
    logic signed [CUR_W-1:0] r_cur;
    logic [OFS_W-1:0]        r_ofs_out;
    t_mode                   r_dmode;
    logic                    r_ovf_out;

    logic [NUM_W-1:0] w_alu_a, w_alu_b, w_alu_res;
    logic             w_alu_sub, w_alu_ge;

    t_acc_ctl         w_acc_ctl;
    logic [SUM_W-1:0] w_sum;
    logic [CNT_W-1:0] w_count;
    logic             w_ovf;

    logic [NUM_W-1:0]   w_sum_q4;
    logic [DEN_W:0]     w_div_t;
    logic [SQ_W-1:0]    w_sq_t;
    logic [SB+1:0]      w_sq_trial;
    logic               w_last_step;
    logic               w_load;
    logic [NUM_W-1:0]   w_q;
    logic [CUR_W-1:0]   w_pos;
    logic [CUR_W:0]     w_nmag;
    logic [CUR_W:0]     w_nval;
    logic [CUR_W-1:0]   w_cur;
    logic [OFS_W-1:0]   w_new_off;
    logic [FSQ_W-1:0]   w_fs_q4;
    logic [OFS_W-1:0]   w_fs_off;

    // Per-sample accumulator
    assign w_acc_ctl.take  = (r_state == S_ACC);
    assign w_acc_ctl.clear = w_load;
    assign w_acc_ctl.ac    = (r_mode == MODE_AC);

    crm_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_sample (r_smp),
        .i_offset (r_offset),
        .o_sum    (w_sum),
        .o_count  (w_count),
        .o_ovf    (w_ovf)
    );

    // Shared add/subtract unit
    crm_alu #(
        .WIDTH (NUM_W)
    ) u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu_res),
        .o_ge  (w_alu_ge)
    );

    assign w_sum_q4    = NUM_W'(w_sum) << Q4_SHIFT;
    assign w_div_t     = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign w_sq_t      = {r_sqr[SQ_W-3:0], r_num[2*SB-1 -: 2]};
    assign w_sq_trial  = {r_root, 2'b01};
    assign w_last_step = (r_cnt == IT_W'(1));
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Steer the shared unit per sequencer step
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        unique case (r_state)
            S_SETUP: begin
                w_alu_a = w_sum_q4;
                w_alu_b = NUM_W'(w_count >> 1);
            end
            S_OMUL, S_SMUL: begin
                w_alu_a = r_num << 1;
                w_alu_b = r_mlt[MLT_W-1] ? NUM_W'(r_mag) : '0;
            end
            S_DIFF: begin
                w_alu_a   = w_sum_q4;
                w_alu_b   = r_num;
                w_alu_sub = 1'b1;
            end
            S_NEG: begin
                w_alu_b   = NUM_W'(r_mag);
                w_alu_sub = 1'b1;
            end
            S_RND: begin
                w_alu_a = r_num;
                w_alu_b = (r_mode == MODE_DC) ?
                          (NUM_W'(w_count) << (SCALE_FRAC + Q4_SHIFT - 1)) :
                          (NUM_W'(1) << (SCALE_FRAC - 1));
            end
            S_DIV: begin
                w_alu_a   = NUM_W'(w_div_t);
                w_alu_b   = NUM_W'(r_den);
                w_alu_sub = 1'b1;
            end
            S_SQRT: begin
                w_alu_a   = NUM_W'(w_sq_t);
                w_alu_b   = NUM_W'(w_sq_trial);
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_mag   = r_mag;
        n_mlt   = r_mlt;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_sqr   = r_sqr;
        n_root  = r_root;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_last ? S_SETUP : S_IDLE;
            end
            S_SETUP: begin
                n_rem = '0;
                n_den = DEN_W'(w_count);
                n_cnt = IT_W'(NUM_W);
                if (r_mode == MODE_CAL) begin
                    n_num   = w_alu_res;
                    n_state = S_DIV;
                end else if (r_mode == MODE_DC) begin
                    n_mag   = MAG_W'(r_offset);
                    n_mlt   = MLT_W'(w_count);
                    n_num   = '0;
                    n_cnt   = IT_W'(MLT_W);
                    n_state = S_OMUL;
                end else begin
                    n_num   = NUM_W'(w_sum);
                    n_state = S_DIV;
                end
            end
            S_OMUL: begin
                n_num = w_alu_res;
                n_mlt = r_mlt << 1;
                n_cnt = r_cnt - IT_W'(1);
                if (w_last_step) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_neg   = !w_alu_ge;
                n_mag   = w_alu_res[MAG_W-1:0];
                n_num   = '0;
                n_mlt   = MLT_W'(r_scale);
                n_cnt   = IT_W'(MLT_W);
                n_state = w_alu_ge ? S_SMUL : S_NEG;
            end
            S_NEG: begin
                n_mag   = w_alu_res[MAG_W-1:0];
                n_state = S_SMUL;
            end
            S_SMUL: begin
                n_num = w_alu_res;
                n_mlt = r_mlt << 1;
                n_cnt = r_cnt - IT_W'(1);
                if (w_last_step) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_num = w_alu_res;
                if (r_mode == MODE_DC) begin
                    n_rem   = '0;
                    n_den   = DEN_W'(w_count) << (SCALE_FRAC + Q4_SHIFT);
                    n_cnt   = IT_W'(NUM_W);
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                n_rem = w_alu_ge ? w_alu_res[DEN_W:0] : w_div_t;
                n_num = {r_num[NUM_W-2:0], w_alu_ge};
                n_cnt = r_cnt - IT_W'(1);
                if (w_last_step) begin
                    if (r_mode == MODE_AC) begin
                        n_sqr   = '0;
                        n_root  = '0;
                        n_cnt   = IT_W'(SB);
                        n_state = S_SQRT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SQRT: begin
                n_sqr  = w_alu_ge ? w_alu_res[SQ_W-1:0] : w_sq_t;
                n_root = {r_root[SB-2:0], w_alu_ge};
                n_num  = r_num << 2;
                n_cnt  = r_cnt - IT_W'(1);
                if (w_last_step) begin
                    n_mag   = MAG_W'(n_root);
                    n_num   = '0;
                    n_mlt   = MLT_W'(r_scale);
                    n_cnt   = IT_W'(MLT_W);
                    n_state = S_SMUL;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Saturate the rounded quotient into the result fields
    assign w_q    = (r_mode == MODE_AC) ? (r_num >> SCALE_FRAC) : r_num;
    assign w_pos  = (w_q > NUM_W'(CUR_POS_MAX)) ? CUR_POS_MAX[CUR_W-1:0] : w_q[CUR_W-1:0];
    assign w_nmag = (w_q > NUM_W'(CUR_NEG_MAX)) ? CUR_NEG_MAX : w_q[CUR_W:0];
    assign w_nval = (CUR_W+1)'(0) - w_nmag;

    always_comb begin
        unique case (r_mode)
            MODE_CAL: w_cur = '0;
            MODE_DC:  w_cur = r_neg ? w_nval[CUR_W-1:0] : w_pos;
            default:  w_cur = w_pos;
        endcase
    end

    assign w_new_off = (r_mode != MODE_CAL) ? r_offset :
                       (r_num > NUM_W'(OFS_MAX)) ? OFS_MAX : r_num[OFS_W-1:0];

    // Half of full scale in Q.4, saturated to the offset width
    assign w_fs_q4  = {i_cfg_data[FS_W-1:0], {(Q4_SHIFT-1){1'b0}}};
    assign w_fs_off = (CMP_W'(w_fs_q4) > CMP_W'(OFS_MAX)) ? OFS_MAX : OFS_W'(w_fs_q4);

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_AC;
            r_scale     <= SCALE_RST;
            r_offset    <= OFS_W'(OFS_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE: begin
                        if (i_cfg_data[MODE_W-1:0] != MODE_UNUSED) begin
                            r_mode <= t_mode'(i_cfg_data[MODE_W-1:0]);
                        end
                    end
                    CFG_SCALE:      r_scale  <= i_cfg_data[SCALE_W-1:0];
                    CFG_FULL_SCALE: r_offset <= w_fs_off;
                    default:        r_scale  <= r_scale;
                endcase
            end else if (w_load) begin
                r_offset <= w_new_off;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_smp  <= i_in.sample;
            r_last <= i_in.last;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_mag  <= n_mag;
        r_mlt  <= n_mlt;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_sqr  <= n_sqr;
        r_root <= n_root;
        if (w_load) begin
            r_cur     <= w_cur;
            r_ofs_out <= w_new_off;
            r_dmode   <= r_mode;
            r_ovf_out <= w_ovf;
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.current_ma      = r_cur;
    assign o_out.offset_out      = r_ofs_out;
    assign o_out.done_mode       = r_dmode;
    assign o_out.window_overflow = r_ovf_out;

    `CRM_ASSERT(a_count_bound, i_clk, i_rst_n, w_count <= CNT_W'(MAX_WINDOW), "count past window limit")
    `CRM_ASSERT(a_div_den, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_den != '0), "divide by zero")
    `CRM_ASSERT(a_setup_count, i_clk, i_rst_n, (r_state == S_SETUP) |-> (w_count != '0), "empty window")
    `CRM_ASSERT_NEXT(a_window_clear, i_clk, i_rst_n, w_load, (w_count == '0) && (w_sum == '0) && !w_ovf, "window state not cleared")
endmodule
